// ===== sv/lla_pkg.sv =====
// shared types, codes and widths for the least-loaded arena assigner
package lla_pkg;

    localparam int ID_W    = 7;   // arena id, 0 means none
    localparam int CNT_W   = 7;   // per-arena user count
    localparam int ACT_W   = 3;
    localparam int STAT_W  = 3;
    localparam int REQ_W   = 6;   // requester number on the port
    localparam int REQ_CODES = 1 << REQ_W;
    localparam int CFG_IDX_W = 2;

    // action codes
    localparam logic [ACT_W-1:0] ACT_GET      = 3'd0;
    localparam logic [ACT_W-1:0] ACT_FORCE    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_RELEASE  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_SET_AUTO = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CREATE   = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK         = 3'd0;
    localparam logic [STAT_W-1:0] STAT_BAD_ID     = 3'd1;
    localparam logic [STAT_W-1:0] STAT_NO_AUTO    = 3'd2;
    localparam logic [STAT_W-1:0] STAT_FULL       = 3'd3;
    localparam logic [STAT_W-1:0] STAT_LAST_AUTO  = 3'd4;
    localparam logic [STAT_W-1:0] STAT_WRONG_MODE = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_LAUNCH,
        S_SCAN,
        S_COMMIT
    } state_t;

    // what stays fixed while a scan runs down the chain
    typedef struct packed {
        logic [ID_W-1:0] total;
        logic [ID_W-1:0] target_id;
        logic [ID_W-1:0] old_id;
    } scan_cmd_t;

    // token handed from cell to cell
    typedef struct packed {
        logic             valid;
        logic [ID_W-1:0]  best_id;
        logic [CNT_W-1:0] best_cnt;
        logic [ID_W-1:0]  first_auto;
        logic [ID_W-1:0]  auto_cnt;
        logic             tgt_auto;
        logic [CNT_W-1:0] tgt_cnt;
        logic [CNT_W-1:0] old_cnt;
    } scan_tok_t;

    // update broadcast to all cells at commit
    typedef struct packed {
        logic            valid;
        logic            inc_en;
        logic [ID_W-1:0] inc_id;
        logic            dec_en;
        logic [ID_W-1:0] dec_id;
        logic            mark_en;
        logic [ID_W-1:0] mark_id;
        logic            mark_val;
    } cell_upd_t;

endpackage

// ===== sv/least_loaded_arena_assigner.sv =====
// top level: item control, requester table and the chain of arena cells
// an item runs table read, token launch, the cell chain scan, then commit; the
//   scan token walks the arena cell chain one cell per cycle. One item at a
//   time: input is taken only in idle, commit waits for a free result register
// reset (aresetn low, synchronous) clears all counts, flags and assignments at once,
//   sets mode 0 and arena limit 64; no clearing pass is needed
module least_loaded_arena_assigner
    import lla_pkg::*;
    #(
        parameter int MAX_ARENAS     = 64,
        parameter int MAX_REQUESTERS = 64
    )
    (
        input  logic                 aclk,
        input  logic                 aresetn,
        // configuration write channel
        input  logic                 cfg_valid,
        output logic                 cfg_ready,
        input  logic [CFG_IDX_W-1:0] cfg_index,
        input  logic [ID_W-1:0]      cfg_data,
        // input items
        input  logic                 s_valid,
        output logic                 s_ready,
        input  logic [ACT_W-1:0]     s_action,
        input  logic [REQ_W-1:0]     s_requester,
        input  logic [ID_W-1:0]      s_target_arena,
        input  logic                 s_auto_flag,
        // result items
        output logic                 m_valid,
        input  logic                 m_ready,
        output logic [ID_W-1:0]      m_arena_out,
        output logic [STAT_W-1:0]    m_status,
        output logic [ID_W-1:0]      m_active_arenas,
        output logic [ID_W-1:0]      m_total_arenas,
        output logic [ID_W-1:0]      m_automatic_arenas
    );

    localparam int REQ_AW = (MAX_REQUESTERS > 1) ? $clog2(MAX_REQUESTERS) : 1;
    localparam logic [ID_W-1:0] ARENA_CAP = ID_W'(MAX_ARENAS);

    // ---------------------------------------------------------------
    // requester number folded into table range, one entry per code
    // ---------------------------------------------------------------
    logic [REQ_AW-1:0] req_fold [REQ_CODES];

    for (genvar g = 0; g < REQ_CODES; g++) begin : g_fold
        assign req_fold[g] = REQ_AW'(g % MAX_REQUESTERS);
    end

    // ---------------------------------------------------------------
    // configuration registers, writes always taken
    // ---------------------------------------------------------------
    logic            mode_reg;
    logic [ID_W-1:0] limit_reg;
    logic [ID_W-1:0] limit_eff;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= 1'b0;
            limit_reg <= ID_W'(64);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_MODE:  mode_reg  <= cfg_data[0];
                CFG_LIMIT: limit_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign limit_eff = (limit_reg < ARENA_CAP) ? limit_reg : ARENA_CAP;

    // ---------------------------------------------------------------
    // control state machine
    // idle -> read requester table -> launch token -> scan -> commit
    // ---------------------------------------------------------------
    state_t state_reg, state_next;
    logic   launch, rd_en, commit_fire, out_free;
    logic   m_valid_reg;

    scan_tok_t tok_chain [MAX_ARENAS+1];
    scan_tok_t scan_reg;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) state_next = S_READ;
            end
            S_READ:   state_next = S_LAUNCH;
            S_LAUNCH: state_next = S_SCAN;
            S_SCAN: begin
                if (tok_chain[MAX_ARENAS].valid) state_next = S_COMMIT;
            end
            S_COMMIT: begin
                // hold until the result register can take the new result
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        rd_en       = 1'b0;
        launch      = 1'b0;
        commit_fire = 1'b0;
        case (state_reg)
            S_IDLE:   s_ready     = 1'b1;
            S_READ:   rd_en       = 1'b1;
            S_LAUNCH: launch      = 1'b1;
            S_SCAN: begin
            end
            S_COMMIT: commit_fire = out_free;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ---------------------------------------------------------------
    // item registers, loaded on the input transfer
    // ---------------------------------------------------------------
    logic [ACT_W-1:0]  act_reg;
    logic [REQ_AW-1:0] req_idx_reg;
    logic [ID_W-1:0]   tgt_reg;
    logic              flag_reg;

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            act_reg     <= s_action;
            req_idx_reg <= req_fold[s_requester];
            tgt_reg     <= s_target_arena;
            flag_reg    <= s_auto_flag;
        end
    end

    // ---------------------------------------------------------------
    // requester table: ram for arena ids plus a valid bit per entry,
    // an entry without its valid bit reads as unassigned
    // ---------------------------------------------------------------
    logic              req_vld_reg [MAX_REQUESTERS];
    logic              old_vld_reg;
    logic [ID_W-1:0]   ram_rdata, ram_wdata, old_id;
    logic              ram_we, vld_clr;

    lla_ram #(
        .WIDTH (ID_W),
        .DEPTH (MAX_REQUESTERS)
    ) u_req_ram (
        .aclk    (aclk),
        .wr_en   (commit_fire && ram_we),
        .wr_addr (req_idx_reg),
        .wr_data (ram_wdata),
        .rd_en   (rd_en),
        .rd_addr (req_idx_reg),
        .rd_data (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_REQUESTERS; i++) begin
                req_vld_reg[i] <= 1'b0;
            end
        end else if (commit_fire) begin
            if (ram_we) begin
                req_vld_reg[req_idx_reg] <= 1'b1;
            end else if (vld_clr) begin
                req_vld_reg[req_idx_reg] <= 1'b0;
            end
        end
    end

    // valid bit sampled alongside the ram read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            old_vld_reg <= req_vld_reg[req_idx_reg];
        end
    end

    assign old_id = old_vld_reg ? ram_rdata : '0;

    // ---------------------------------------------------------------
    // arena cell chain, token enters at cell 0 on launch
    // ---------------------------------------------------------------
    logic [ID_W-1:0] total_reg, total_next;
    logic [ID_W-1:0] active_reg, active_next;
    logic [ID_W-1:0] shared_reg, shared_next;
    scan_cmd_t       scan_cmd;
    cell_upd_t       upd;

    assign scan_cmd.total     = total_reg;
    assign scan_cmd.target_id = tgt_reg;
    assign scan_cmd.old_id    = old_id;

    always_comb begin
        tok_chain[0]       = '0;
        tok_chain[0].valid = launch;
    end

    for (genvar g = 0; g < MAX_ARENAS; g++) begin : g_cell
        lla_cell #(
            .CELL_ID (g)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cmd     (scan_cmd),
            .tok_in  (tok_chain[g]),
            .tok_out (tok_chain[g+1]),
            .upd     (upd)
        );
    end

    // hold the token as it leaves the last cell
    always_ff @(posedge aclk) begin
        if (tok_chain[MAX_ARENAS].valid) begin
            scan_reg <= tok_chain[MAX_ARENAS];
        end
    end

    // ---------------------------------------------------------------
    // commit: decide the action from the scan summary
    // ---------------------------------------------------------------
    logic [ID_W-1:0]   res_arena;
    logic [STAT_W-1:0] res_status;
    logic              tgt_ok;
    logic              act_inc, act_dec, auto_inc, auto_dec;
    logic [ID_W-1:0]   auto_next;

    assign tgt_ok = (tgt_reg != '0) && (tgt_reg <= total_reg);

    always_comb begin
        res_arena   = '0;
        res_status  = STAT_OK;
        upd         = '0;
        upd.valid   = commit_fire;
        ram_we      = 1'b0;
        ram_wdata   = '0;
        vld_clr     = 1'b0;
        total_next  = total_reg;
        shared_next = shared_reg;
        act_inc     = 1'b0;
        act_dec     = 1'b0;
        auto_inc    = 1'b0;
        auto_dec    = 1'b0;
        case (act_reg)
            ACT_GET: begin
                if (!mode_reg) begin
                    if (old_id != '0) begin
                        res_arena = old_id;
                    end else if (scan_reg.best_id == '0) begin
                        res_status = STAT_NO_AUTO;
                    end else begin
                        // new requester joins the least loaded automatic arena
                        res_arena  = scan_reg.best_id;
                        upd.inc_en = 1'b1;
                        upd.inc_id = scan_reg.best_id;
                        act_inc    = (scan_reg.best_cnt == '0);
                        ram_we     = 1'b1;
                        ram_wdata  = scan_reg.best_id;
                    end
                end else begin
                    if (shared_reg != '0) begin
                        res_arena = shared_reg;
                    end else if (scan_reg.first_auto == '0) begin
                        res_status = STAT_NO_AUTO;
                    end else begin
                        res_arena   = scan_reg.first_auto;
                        shared_next = scan_reg.first_auto;
                    end
                end
            end
            ACT_FORCE: begin
                if (mode_reg) begin
                    res_status = STAT_WRONG_MODE;
                end else if (!tgt_ok) begin
                    res_status = STAT_BAD_ID;
                end else begin
                    res_arena = tgt_reg;
                    // forcing onto the arena already held changes nothing
                    if (old_id != tgt_reg) begin
                        if (old_id != '0 && scan_reg.old_cnt != '0) begin
                            upd.dec_en = 1'b1;
                            upd.dec_id = old_id;
                            act_dec    = (scan_reg.old_cnt == CNT_W'(1));
                        end
                        upd.inc_en = 1'b1;
                        upd.inc_id = tgt_reg;
                        act_inc    = (scan_reg.tgt_cnt == '0);
                        ram_we     = 1'b1;
                        ram_wdata  = tgt_reg;
                    end
                end
            end
            ACT_RELEASE: begin
                if (mode_reg) begin
                    res_status = STAT_WRONG_MODE;
                end else begin
                    res_arena = old_id;
                    if (old_id != '0) begin
                        if (scan_reg.old_cnt != '0) begin
                            upd.dec_en = 1'b1;
                            upd.dec_id = old_id;
                            act_dec    = (scan_reg.old_cnt == CNT_W'(1));
                        end
                        vld_clr = 1'b1;
                    end
                end
            end
            ACT_SET_AUTO: begin
                if (!tgt_ok) begin
                    res_status = STAT_BAD_ID;
                end else begin
                    res_arena = tgt_reg;
                    // the last automatic arena keeps its flag
                    if (scan_reg.tgt_auto && !flag_reg &&
                        scan_reg.auto_cnt <= ID_W'(1)) begin
                        res_status = STAT_LAST_AUTO;
                    end else begin
                        upd.mark_en  = 1'b1;
                        upd.mark_id  = tgt_reg;
                        upd.mark_val = flag_reg;
                        auto_inc     = !scan_reg.tgt_auto && flag_reg;
                        auto_dec     = scan_reg.tgt_auto && !flag_reg;
                    end
                end
            end
            ACT_CREATE: begin
                if (total_reg >= limit_eff) begin
                    res_status = STAT_FULL;
                end else begin
                    total_next   = total_reg + ID_W'(1);
                    res_arena    = total_next;
                    upd.mark_en  = 1'b1;
                    upd.mark_id  = total_next;
                    upd.mark_val = flag_reg;
                    auto_inc     = flag_reg;
                end
            end
            default: begin
            end
        endcase

        active_next = active_reg + ID_W'(act_inc)
                    - ID_W'(act_dec && active_reg != '0);
        auto_next   = scan_reg.auto_cnt + ID_W'(auto_inc) - ID_W'(auto_dec);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg  <= '0;
            active_reg <= '0;
            shared_reg <= '0;
        end else if (commit_fire) begin
            total_reg  <= total_next;
            active_reg <= active_next;
            shared_reg <= shared_next;
        end
    end

    // ---------------------------------------------------------------
    // result register, frees the control path while a result waits
    // ---------------------------------------------------------------
    logic [ID_W-1:0]   m_arena_reg, m_active_reg, m_total_reg, m_auto_reg;
    logic [STAT_W-1:0] m_status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (commit_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (commit_fire) begin
            m_arena_reg  <= res_arena;
            m_status_reg <= res_status;
            m_active_reg <= active_next;
            m_total_reg  <= total_next;
            m_auto_reg   <= auto_next;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_arena_out        = m_arena_reg;
    assign m_status           = m_status_reg;
    assign m_active_arenas    = m_active_reg;
    assign m_total_arenas     = m_total_reg;
    assign m_automatic_arenas = m_auto_reg;

endmodule

// ===== sv/lla_ram.sv =====
// generic single-write, registered-read ram
module lla_ram
    #(
        parameter int WIDTH = 7,
        parameter int DEPTH = 64
    )
    (
        input  logic                                  aclk,
        input  logic                                  wr_en,
        input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
        input  logic [WIDTH-1:0]                      wr_data,
        input  logic                                  rd_en,
        input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
        output logic [WIDTH-1:0]                      rd_data
    );

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/lla_cell.sv =====
// one arena slot: user count, automatic flag and one stage of the scan chain
module lla_cell
    import lla_pkg::*;
    #(
        parameter int CELL_ID = 0
    )
    (
        input  logic      aclk,
        input  logic      aresetn,
        input  scan_cmd_t cmd,
        input  scan_tok_t tok_in,
        output scan_tok_t tok_out,
        input  cell_upd_t upd
    );

    localparam logic [ID_W-1:0] MY_ID = ID_W'(CELL_ID + 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             auto_reg, auto_next;
    scan_tok_t        tok_reg, tok_next;
    logic             created, inc_hit, dec_hit;

    assign created = (MY_ID <= cmd.total);

    // fold this arena into the passing token
    always_comb begin
        tok_next = tok_in;
        if (created && auto_reg) begin
            tok_next.auto_cnt = tok_in.auto_cnt + ID_W'(1);
            if (tok_in.first_auto == '0) begin
                tok_next.first_auto = MY_ID;
            end
            if (tok_in.best_id == '0 || count_reg < tok_in.best_cnt) begin
                tok_next.best_id  = MY_ID;
                tok_next.best_cnt = count_reg;
            end
        end
        if (cmd.target_id == MY_ID) begin
            tok_next.tgt_auto = auto_reg;
            tok_next.tgt_cnt  = count_reg;
        end
        if (cmd.old_id == MY_ID) begin
            tok_next.old_cnt = count_reg;
        end
    end

    assign inc_hit = upd.valid && upd.inc_en && (upd.inc_id == MY_ID);
    assign dec_hit = upd.valid && upd.dec_en && (upd.dec_id == MY_ID);

    always_comb begin
        count_next = count_reg + CNT_W'(inc_hit) - CNT_W'(dec_hit);
        auto_next  = auto_reg;
        if (upd.valid && upd.mark_en && upd.mark_id == MY_ID) begin
            auto_next = upd.mark_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            auto_reg      <= 1'b0;
            tok_reg.valid <= 1'b0;
        end else begin
            count_reg     <= count_next;
            auto_reg      <= auto_next;
            tok_reg.valid <= tok_next.valid;
        end
        tok_reg.best_id    <= tok_next.best_id;
        tok_reg.best_cnt   <= tok_next.best_cnt;
        tok_reg.first_auto <= tok_next.first_auto;
        tok_reg.auto_cnt   <= tok_next.auto_cnt;
        tok_reg.tgt_auto   <= tok_next.tgt_auto;
        tok_reg.tgt_cnt    <= tok_next.tgt_cnt;
        tok_reg.old_cnt    <= tok_next.old_cnt;
    end

    assign tok_out = tok_reg;

endmodule
